// ----- rtl/core/sab_pkg.sv -----
// Shared types, widths and codes for the suffix array builder.
package sab_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SYM_W       = 8;
    localparam int POS_W       = 9;
    localparam int STAT_W      = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sort_stat;

endpackage

// ----- rtl/core/suffix_array_builder.sv -----
// Top level: text and order stores, push/read handling, build sequencer.
//
//  channel   | handshake            | fields
//  ----------+----------------------+-------------------------------------------
//  command   | start / busy         | i_op, i_symbol, i_last, i_position
//  result    | o_strobe (1 cycle)   | o_suffix_start, o_status
//
// Push and read words are taken one per cycle while busy is low; a read answers
// on the next cycle. A push marked last raises busy for the build: with m =
// length+1, a text load, then ceil(log2 m) rounds, one key compare per cycle in
// the shared comparator, counting for each suffix how many keys sort below it.
// Reset (synchronous, active low) clears length, built flag and the sequencer.
// Results cannot be stalled; each is shown for exactly one cycle.
module suffix_array_builder #(
    parameter int MAX_LEN = sab_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [sab_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_last,
    input  logic [sab_pkg::POS_W-1:0]   i_position,
    output logic                        o_strobe,
    output logic [sab_pkg::POS_W-1:0]   o_suffix_start,
    output logic [sab_pkg::STAT_W-1:0]  o_status
);
    import sab_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int TW = $clog2(MAX_LEN);
    localparam int CW = (AW > POS_W) ? AW : POS_W;

    logic [AW-1:0]     r_len, n_len, base;
    logic              r_built, n_built;
    logic              r_rd_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic              acc, acc_push, acc_rd, room;
    t_sort_stat        stat;
    logic [TW-1:0]     text_raddr;
    logic [SYM_W-1:0]  text_q;
    logic              ord_we;
    logic [AW-1:0]     ord_waddr, ord_wdata, ord_q;

    assign acc      = start && !busy;
    assign acc_push = acc && (i_op == OP_PUSH);
    assign acc_rd   = acc && (i_op == OP_READ);
    // a push after a build starts a fresh string
    assign base     = r_built ? '0 : r_len;
    assign room     = base < AW'(MAX_LEN);

    always_comb begin
        n_len   = r_len;
        n_built = r_built | stat.done;
        if (acc_push) begin
            n_built = 1'b0;
            n_len   = room ? (base + AW'(1)) : base;
        end
    end

    always_comb begin
        if (!r_built) begin
            n_status = STAT_NOT_BUILT;
        end else if (CW'(i_position) > CW'(r_len)) begin
            n_status = STAT_RANGE;
        end else begin
            n_status = STAT_OK;
        end
    end

    sab_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .ADDR_W(TW)) u_text (
        .i_clk   (i_clk),
        .i_we    (acc_push && room),
        .i_waddr (base[TW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (text_raddr),
        .o_rdata (text_q)
    );

    sab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1), .ADDR_W(AW)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (AW'(i_position)),
        .o_rdata (ord_q)
    );

    sab_sorter #(.MAX_LEN(MAX_LEN), .AW(AW), .TW(TW)) u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (acc_push && i_last),
        .i_len       (n_len),
        .o_text_addr (text_raddr),
        .i_text_data (text_q),
        .o_ord_we    (ord_we),
        .o_ord_addr  (ord_waddr),
        .o_ord_data  (ord_wdata),
        .o_stat      (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_built    <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_built    <= n_built;
            r_rd_valid <= acc_rd;
        end
        if (acc_rd) begin
            r_status <= n_status;
        end
    end

    assign busy           = stat.busy;
    assign o_strobe       = r_rd_valid;
    assign o_status       = r_status;
    assign o_suffix_start = (r_status == STAT_OK) ? POS_W'(ord_q) : '0;

`ifndef NO_ASSERTIONS
    a_strobe_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(acc_rd && i_rst_n) |-> o_strobe)
        else $error("read word gave no result");
    a_strobe_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(acc_rd))
        else $error("result without a read word");
    a_build_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> r_built)
        else $error("build ended without built flag");
    a_ok_needs_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_OK)) |-> $past(r_built))
        else $error("ok status on an unbuilt string");
`endif
endmodule

// ----- rtl/core/sab_ram.sv -----
// Generic single write port RAM with registered read.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/sab_keycmp.sv -----
// Shared key comparator: (hi, lo) pair of A strictly below that of B.
module sab_keycmp #(
    parameter int RW = 9
) (
    input  logic [RW-1:0] i_hi_a,
    input  logic [RW:0]   i_lo_a,
    input  logic [RW-1:0] i_hi_b,
    input  logic [RW:0]   i_lo_b,
    output logic          o_less
);
    assign o_less = (i_hi_a < i_hi_b) || ((i_hi_a == i_hi_b) && (i_lo_a < i_lo_b));
endmodule

// ----- rtl/core/sab_sorter.sv -----
// Prefix doubling sequencer: rank banks, counting scan and order writes.
module sab_sorter #(
    parameter int MAX_LEN = sab_pkg::MAX_LEN_DEF,
    parameter int AW = $clog2(MAX_LEN + 1),
    parameter int TW = $clog2(MAX_LEN)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [AW-1:0]              i_len,
    output logic [TW-1:0]              o_text_addr,
    input  logic [sab_pkg::SYM_W-1:0]  i_text_data,
    output logic                       o_ord_we,
    output logic [AW-1:0]              o_ord_addr,
    output logic [AW-1:0]              o_ord_data,
    output sab_pkg::t_sort_stat        o_stat
);
    import sab_pkg::*;

    localparam int RW = (AW > SYM_W + 1) ? AW : SYM_W + 1;
    localparam int CW = AW + 1;
    localparam int KW = AW + 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_m, n_m;
    logic [KW-1:0] r_k, n_k;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_bank, n_bank, r_lov;
    logic [RW-1:0] r_hi_i, n_hi_i;
    logic [RW:0]   r_lo_i, n_lo_i;

    logic [CW-1:0] addr_a_full, j_m1;
    logic [KW-1:0] addr_b_full, k_dbl;
    logic          b_in, last_i, last_round, less;
    logic [RW-1:0] q0a, q0b, q1a, q1b, rd_a, rd_b, wdata;
    logic [RW:0]   lo_cur;
    logic [AW-1:0] waddr;
    logic          we0, we1;

    assign addr_a_full = (r_state == ST_FETCH) ? r_i : r_j;
    assign addr_b_full = KW'(addr_a_full) + r_k;
    assign b_in        = addr_b_full < KW'(r_m);
    assign j_m1        = r_j - CW'(1);
    assign k_dbl       = r_k << 1;
    assign last_i      = (r_i + CW'(1)) == r_m;
    assign last_round  = k_dbl >= KW'(r_m);

    assign rd_a   = r_bank ? q1a : q0a;
    assign rd_b   = r_bank ? q1b : q0b;
    // nothing k ahead counts below every real rank
    assign lo_cur = r_lov ? ({1'b0, rd_b} + (RW+1)'(1)) : '0;

    sab_keycmp #(.RW(RW)) u_cmp (
        .i_hi_a (rd_a),
        .i_lo_a (lo_cur),
        .i_hi_b (r_hi_i),
        .i_lo_b (r_lo_i),
        .o_less (less)
    );

    // rank banks, each held twice for the i-or-j and the k-ahead read ports
    assign we0   = ((r_state == ST_LOAD) && (r_j != '0)) || ((r_state == ST_WRITE) && r_bank);
    assign we1   = (r_state == ST_WRITE) && !r_bank;
    assign waddr = (r_state == ST_LOAD) ? j_m1[AW-1:0] : r_i[AW-1:0];
    assign wdata = (r_state == ST_LOAD)
                 ? ((r_j < r_m) ? (RW'(i_text_data) + RW'(1)) : '0)
                 : RW'(r_cnt);

    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1), .ADDR_W(AW)) u_rank0a (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_a_full[AW-1:0]), .o_rdata(q0a));
    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1), .ADDR_W(AW)) u_rank0b (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_b_full[AW-1:0]), .o_rdata(q0b));
    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1), .ADDR_W(AW)) u_rank1a (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_a_full[AW-1:0]), .o_rdata(q1a));
    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1), .ADDR_W(AW)) u_rank1b (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_b_full[AW-1:0]), .o_rdata(q1b));

    assign o_text_addr = r_j[TW-1:0];
    assign o_ord_we    = (r_state == ST_WRITE);
    assign o_ord_addr  = r_cnt;
    assign o_ord_data  = r_i[AW-1:0];
    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_WRITE) && last_i && last_round;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_LOAD;
            ST_LOAD:  if (r_j == r_m) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_SCAN;
            ST_SCAN:  if (r_j == r_m) n_state = ST_WRITE;
            ST_WRITE: n_state = (last_i && last_round) ? ST_IDLE : ST_FETCH;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_m    = r_m;
        n_k    = r_k;
        n_cnt  = r_cnt;
        n_bank = r_bank;
        n_hi_i = r_hi_i;
        n_lo_i = r_lo_i;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_m    = CW'(i_len) + CW'(1);
                    n_i    = '0;
                    n_j    = '0;
                    n_k    = KW'(1);
                    n_bank = 1'b0;
                end
            end
            ST_LOAD: n_j = r_j + CW'(1);
            ST_FETCH: begin
                n_j   = '0;
                n_cnt = '0;
            end
            ST_SCAN: begin
                n_j = r_j + CW'(1);
                // first word back is the key of suffix i itself
                if (r_j == '0) begin
                    n_hi_i = rd_a;
                    n_lo_i = lo_cur;
                end else if (less) begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_WRITE: begin
                if (last_i) begin
                    n_i    = '0;
                    n_k    = k_dbl;
                    n_bank = ~r_bank;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_m    <= n_m;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_bank <= n_bank;
        r_hi_i <= n_hi_i;
        r_lo_i <= n_lo_i;
        r_lov  <= b_in;
    end
endmodule
